// File: rtl/tsna_pkg.sv
// Package for the timestamp arithmetic unit: command codes, timing constants
// and the operand and result structs passed between the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps

package tsna_pkg;

    // Widths of the timestamp fields.
    localparam int SECS_W  = 64;
    localparam int NANOS_W = 30;
    localparam int CMD_W   = 2;

    // Nanosecond limits and the far-future instant used on add overflow.
    localparam logic [NANOS_W-1:0] NS_PER_SEC      = 30'd1000000000;
    localparam logic [NANOS_W-1:0] NS_MAX          = 30'd999999999;
    localparam logic [SECS_W-1:0]  FAR_FUTURE_SECS = 64'd1 << 48;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SINCE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ABSDIFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SUB     = 2'd3;

    // One operand word after nanosecond clamping.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SECS_W-1:0]  a_secs;
        logic [NANOS_W-1:0] a_nanos;
        logic [SECS_W-1:0]  b_secs;
        logic [NANOS_W-1:0] b_nanos;
    } operand_t;

    // One result word.
    typedef struct packed {
        logic [SECS_W-1:0]  res_secs;
        logic [NANOS_W-1:0] res_nanos;
        logic               saturated;
    } result_t;

endpackage

// File: rtl/timestamp_secs_nanos_alu.sv
// Top level of the timestamp arithmetic unit: input operand register,
// datapath instance and result register with stream handshakes.
// Depends on tsna_pkg and tsna_alu.
`timescale 1ns / 1ps

// Channel  Dir  Data (tdata, low bits first)                 Side (tuser)
// s_       in   a_secs, a_nanos, b_secs, b_nanos (192 bits)  command (2 bits)
// m_       out  res_secs, res_nanos (96 bits)                saturated (1 bit)
//
// A word accepted from s_ is captured in the operand register, with nanoseconds
// clamped on capture, and moves on to the result register once the result slot
// is free; the datapath between the two registers works on it in the meantime.
// A word is accepted every cycle while m_tready is high (single-pass datapath).
// Reset clears both valid flags; payload registers are not reset.
// When the result is stalled, the operand stage holds one more word before
// s_tready falls.

module timestamp_secs_nanos_alu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // a_secs, a_nanos, b_secs, b_nanos, zero pad
    input  logic [1:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // res_secs, res_nanos, zero pad
    output logic [0:0]   m_tuser    // saturated
);

    tsna_pkg::operand_t op_reg, op_next;
    logic               op_valid_reg, op_valid_next;
    tsna_pkg::result_t  res_reg, res_next;
    logic               res_valid_reg, res_valid_next;
    tsna_pkg::result_t  alu_res;
    logic               advance;
    logic               s_accept;

    logic [tsna_pkg::NANOS_W-1:0] in_a_nanos;
    logic [tsna_pkg::NANOS_W-1:0] in_b_nanos;

    // Stage handshakes: the operand stage moves on when the result slot is free.
    assign advance  = op_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !op_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Nanoseconds above the legal range are clamped on capture.
    assign in_a_nanos = (s_tdata[93:64] > tsna_pkg::NS_MAX) ? tsna_pkg::NS_MAX
                                                            : s_tdata[93:64];
    assign in_b_nanos = (s_tdata[187:158] > tsna_pkg::NS_MAX) ? tsna_pkg::NS_MAX
                                                              : s_tdata[187:158];

    // Operand stage next state.
    always_comb begin
        op_next       = op_reg;
        op_valid_next = op_valid_reg;
        if (s_accept) begin
            op_next.command = s_tuser;
            op_next.a_secs  = s_tdata[63:0];
            op_next.a_nanos = in_a_nanos;
            op_next.b_secs  = s_tdata[157:94];
            op_next.b_nanos = in_b_nanos;
            op_valid_next   = 1'b1;
        end else if (advance) begin
            op_valid_next = 1'b0;
        end
    end

    tsna_alu u_alu (
        .op  (op_reg),
        .res (alu_res)
    );

    // Result stage next state.
    always_comb begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (advance) begin
            res_next       = alu_res;
            res_valid_next = 1'b1;
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end
    end

    // Valid flags are reset; payloads are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    // Output packing.
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00, res_reg.res_nanos, res_reg.res_secs};
    assign m_tuser  = res_reg.saturated;

    // A flagged result is either the far-future instant or zero, always 0 ns.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            ((m_tdata[63:0] == tsna_pkg::FAR_FUTURE_SECS || m_tdata[63:0] == '0)
             && m_tdata[93:64] == '0))
        else $error("saturated result has unexpected value");

    // Result nanoseconds stay below one second.
    a_nanos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[93:64] < tsna_pkg::NS_PER_SEC))
        else $error("result nanoseconds out of range");

    // With both stages full and the output stalled, no word is taken in.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full");

    // An operand word that moves on lands in the result register.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced word lost");

endmodule

// File: rtl/tsna_alu.sv
// Combinational datapath of the timestamp arithmetic unit: ordering compare,
// borrow subtract in both directions and carry add with saturation.
// Depends on tsna_pkg.
`timescale 1ns / 1ps

module tsna_alu (
    input  tsna_pkg::operand_t op,
    output tsna_pkg::result_t  res
);

    // Subtract y from x with a nanosecond borrow; x is not earlier than y.
    function automatic tsna_pkg::result_t diff_ts(
        input logic [tsna_pkg::SECS_W-1:0]  xs,
        input logic [tsna_pkg::NANOS_W-1:0] xn,
        input logic [tsna_pkg::SECS_W-1:0]  ys,
        input logic [tsna_pkg::NANOS_W-1:0] yn
    );
        tsna_pkg::result_t            r;
        logic                         borrow;
        logic [tsna_pkg::NANOS_W:0]   n_wide;
        borrow = (xn < yn);
        n_wide = {1'b0, xn} - {1'b0, yn}
                 + (borrow ? {1'b0, tsna_pkg::NS_PER_SEC} : '0);
        r.res_secs  = xs - ys - {{(tsna_pkg::SECS_W-1){1'b0}}, borrow};
        r.res_nanos = n_wide[tsna_pkg::NANOS_W-1:0];
        r.saturated = 1'b0;
        return r;
    endfunction

    logic                          a_earlier;
    tsna_pkg::result_t             diff_ab;
    tsna_pkg::result_t             diff_ba;
    logic [tsna_pkg::NANOS_W:0]    add_n;
    logic                          add_carry;
    logic [tsna_pkg::SECS_W:0]     add_s;
    logic [tsna_pkg::NANOS_W:0]    add_n_adj;

    // A is earlier than B when its seconds, then its nanoseconds, are smaller.
    assign a_earlier = {op.a_secs, op.a_nanos} < {op.b_secs, op.b_nanos};

    // Both subtraction directions are built in parallel.
    assign diff_ab = diff_ts(op.a_secs, op.a_nanos, op.b_secs, op.b_nanos);
    assign diff_ba = diff_ts(op.b_secs, op.b_nanos, op.a_secs, op.a_nanos);

    // Add with a carry into the seconds at one billion nanoseconds; bit 64 of
    // the seconds sum flags overflow from either source.
    assign add_n     = {1'b0, op.a_nanos} + {1'b0, op.b_nanos};
    assign add_carry = (add_n >= {1'b0, tsna_pkg::NS_PER_SEC});
    assign add_n_adj = add_n - (add_carry ? {1'b0, tsna_pkg::NS_PER_SEC} : '0);
    assign add_s     = {1'b0, op.a_secs} + {1'b0, op.b_secs}
                       + {{tsna_pkg::SECS_W{1'b0}}, add_carry};

    // Select the result for the command.
    always_comb begin
        res = '0;
        unique case (op.command)
            tsna_pkg::CMD_SINCE: begin
                if (!a_earlier) begin
                    res = diff_ab;
                end
            end
            tsna_pkg::CMD_ABSDIFF: begin
                res = a_earlier ? diff_ba : diff_ab;
            end
            tsna_pkg::CMD_ADD: begin
                if (add_s[tsna_pkg::SECS_W]) begin
                    res.res_secs  = tsna_pkg::FAR_FUTURE_SECS;
                    res.saturated = 1'b1;
                end else begin
                    res.res_secs  = add_s[tsna_pkg::SECS_W-1:0];
                    res.res_nanos = add_n_adj[tsna_pkg::NANOS_W-1:0];
                end
            end
            tsna_pkg::CMD_SUB: begin
                if (a_earlier) begin
                    res.saturated = 1'b1;
                end else begin
                    res = diff_ab;
                end
            end
        endcase
    end

endmodule
